// File: src/pq_pkg.sv
// Package: shared constants and types for the playlist queue.
package pq_pkg;

  localparam int unsigned Entries = 64;
  localparam int unsigned IdW     = 6;
  localparam int unsigned DurW    = 16;
  localparam int unsigned LenW    = 7;
  localparam int unsigned TotW    = 23;
  localparam int unsigned OutTotW = 22;
  localparam int unsigned MaxRes  = 64;

  localparam logic [2:0] OpRegister = 3'd0;
  localparam logic [2:0] OpEnqueue  = 3'd1;
  localparam logic [2:0] OpPlay     = 3'd2;
  localparam logic [2:0] OpRecent   = 3'd3;
  localparam logic [2:0] OpDelete   = 3'd4;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StExists   = 2'd1;
  localparam logic [1:0] StUnknown  = 2'd2;
  localparam logic [1:0] StEmpty    = 2'd3;

  typedef struct packed {
    logic [2:0]      opcode;
    logic [IdW-1:0]  song_id;
    logic [DurW-1:0] duration;
    logic [6:0]      count_asked;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [IdW-1:0]     result_song;
    logic               result_valid;
    logic               last;
    logic [OutTotW-1:0] queue_total;
    logic [IdW-1:0]     front_song;
    logic               front_valid;
  } res_t;

  // One entry of the main memory: duration and all four links.
  typedef struct packed {
    logic [DurW-1:0] dur;
    logic [IdW-1:0]  qn;
    logic [IdW-1:0]  qp;
    logic [IdW-1:0]  hn;
    logic [IdW-1:0]  hp;
  } ent_t;

  // Field select masks for a partial write.
  typedef struct packed {
    logic dur;
    logic qn;
    logic qp;
    logic hn;
    logic hp;
  } wmask_t;

endpackage

// File: src/pq_if.sv
// Interfaces: command and result channels.
interface pq_cmd_if;
  logic         valid;
  logic         ready;
  pq_pkg::cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pq_res_if;
  logic         valid;
  logic         ready;
  pq_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/playlist_queue_with_mru_history.sv
// Top level: playlist registry, FIFO play queue and MRU history list.
//
//  channel | dir | payload                                   | transfer
//  cmd     | in  | opcode, song_id, duration, count_asked    | valid & ready
//  res     | out | status, result_song/valid, last, totals    | valid & ready
//
// One command at a time, sequenced around the entry memory (one read port, one
// write port, registered read); neighbour links are written one per cycle.
// Register, errors and no-ops go straight to S_OUT; enqueue passes S_RD, S_PUSH,
// S_PUSH2; delete S_RD and the unlink states S_QP to S_HN; play S_RD, the unlink
// states, then S_PUSH and S_PUSH2; recent alternates S_WALK and S_WOUT.
// Reset clears flags, list pointers, lengths and total; the memory is not
// cleared, every entry is written before it is read. A waiting result blocks
// the command input and pauses a recent listing.
module playlist_queue_with_mru_history (
  input logic       clk_i,
  input logic       rst_ni,
  pq_cmd_if.sink    cmd,
  pq_res_if.source  res
);
  localparam int unsigned IdW = pq_pkg::IdW;
  localparam logic [pq_pkg::LenW-1:0] LenOne = pq_pkg::LenW'(1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;  // wait on read of target entry
  localparam logic [3:0] S_QP    = 4'd2;  // fix queue prev's next
  localparam logic [3:0] S_QN    = 4'd3;  // fix queue next's prev
  localparam logic [3:0] S_HP    = 4'd4;  // fix history prev's next
  localparam logic [3:0] S_HN    = 4'd5;  // fix history next's prev
  localparam logic [3:0] S_PUSH  = 4'd6;  // push to history front / queue back
  localparam logic [3:0] S_PUSH2 = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_WALK  = 4'd9;  // recent: wait on read
  localparam logic [3:0] S_WOUT  = 4'd10; // recent: present one entry

  logic [3:0] state_q, state_d;
  pq_pkg::cmd_t cmd_q, cmd_d;

  logic [pq_pkg::Entries-1:0] reg_q, reg_d, qd_q, qd_d, hi_q, hi_d;
  logic [IdW-1:0] qh_q, qh_d, qt_q, qt_d, hh_q, hh_d, ht_q, ht_d;
  logic [pq_pkg::LenW-1:0] ql_q, ql_d, hl_q, hl_d;
  logic [pq_pkg::TotW-1:0] tot_q, tot_d;

  pq_pkg::ent_t ent_q, ent_d;        // latched links of target
  logic [IdW-1:0] sid_q, sid_d;      // target entry
  logic was_q_q, was_q_d, was_h_q, was_h_d;
  logic [pq_pkg::LenW-1:0] cnt_q, cnt_d;
  logic [IdW-1:0] cur_q, cur_d;

  pq_pkg::res_t out_q, out_d;
  logic ov_q, ov_d;

  logic re;
  logic [IdW-1:0] raddr;
  pq_pkg::ent_t rdata, wdata;
  logic we;
  logic [IdW-1:0] waddr;
  pq_pkg::wmask_t wmask;

  pq_mem u_mem (
    .clk_i, .re_i(re), .raddr_i(raddr), .rdata_o(rdata),
    .we_i(we), .waddr_i(waddr), .wmask_i(wmask), .wdata_i(wdata)
  );

  assign cmd.ready = (state_q == S_IDLE) && !ov_q;
  assign res.valid = ov_q;
  assign res.data  = out_q;

  always_comb begin
    logic [pq_pkg::LenW-1:0] ask;
    ask = (cmd.data.count_asked > 7'(pq_pkg::MaxRes)) ? 7'(pq_pkg::MaxRes)
                                                      : cmd.data.count_asked;
    state_d = state_q; cmd_d = cmd_q;
    reg_d = reg_q; qd_d = qd_q; hi_d = hi_q;
    qh_d = qh_q; qt_d = qt_q; hh_d = hh_q; ht_d = ht_q;
    ql_d = ql_q; hl_d = hl_q; tot_d = tot_q;
    ent_d = ent_q; sid_d = sid_q; was_q_d = was_q_q; was_h_d = was_h_q;
    cnt_d = cnt_q; cur_d = cur_q;
    out_d = out_q; ov_d = ov_q;
    re = 1'b0; raddr = sid_q;
    we = 1'b0; waddr = sid_q; wmask = '0; wdata = '0;

    if (ov_q && res.ready) ov_d = 1'b0;

    // Default result frame: filled in at S_OUT / S_WOUT.
    case (state_q)
      S_IDLE: begin
        if (cmd.valid && !ov_q) begin
          cmd_d = cmd.data;
          sid_d = cmd.data.song_id;
          out_d.status = pq_pkg::StOk;
          out_d.result_song = '0;
          out_d.result_valid = 1'b0;
          state_d = S_OUT;
          case (cmd.data.opcode)
            pq_pkg::OpRegister: begin
              if (reg_q[cmd.data.song_id]) begin
                out_d.status = pq_pkg::StExists;
              end else begin
                reg_d[cmd.data.song_id] = 1'b1;
                qd_d[cmd.data.song_id] = 1'b0;
                hi_d[cmd.data.song_id] = 1'b0;
                we = 1'b1; waddr = cmd.data.song_id;
                wmask.dur = 1'b1; wdata.dur = cmd.data.duration;
              end
            end
            pq_pkg::OpEnqueue: begin
              if (!reg_q[cmd.data.song_id]) begin
                out_d.status = pq_pkg::StUnknown;
              end else if (!qd_q[cmd.data.song_id]) begin
                re = 1'b1; raddr = cmd.data.song_id;
                state_d = S_RD;
              end
            end
            pq_pkg::OpPlay: begin
              if (ql_q == '0) begin
                out_d.status = pq_pkg::StEmpty;
              end else begin
                sid_d = qh_q;
                re = 1'b1; raddr = qh_q;
                state_d = S_RD;
              end
            end
            pq_pkg::OpRecent: begin
              cnt_d = (ask > hl_q) ? hl_q : ask;
              if (((ask > hl_q) ? hl_q : ask) != '0) begin
                cur_d = hh_q;
                re = 1'b1; raddr = hh_q;
                state_d = S_WALK;
              end
            end
            pq_pkg::OpDelete: begin
              if (reg_q[cmd.data.song_id]) begin
                re = 1'b1; raddr = cmd.data.song_id;
                state_d = S_RD;
              end
            end
            default: ;
          endcase
        end
      end

      S_RD: begin
        ent_d = rdata;
        was_q_d = qd_q[sid_q];
        was_h_d = hi_q[sid_q];
        state_d = (cmd_q.opcode == pq_pkg::OpEnqueue) ? S_PUSH : S_QP;
      end

      // Queue unlink: head moves on, or the prev entry skips the target.
      S_QP: begin
        state_d = S_QN;
        if (was_q_q) begin
          qd_d[sid_q] = 1'b0;
          tot_d = tot_q - pq_pkg::TotW'(ent_q.dur);
          if (ql_q != '0) ql_d = ql_q - LenOne;
          if (sid_q == qh_q) begin
            qh_d = ent_q.qn;
          end else begin
            we = 1'b1; waddr = ent_q.qp; wmask.qn = 1'b1; wdata.qn = ent_q.qn;
          end
        end
      end

      S_QN: begin
        state_d = S_HP;
        if (was_q_q) begin
          if (sid_q == qt_q) begin
            qt_d = ent_q.qp;
          end else begin
            we = 1'b1; waddr = ent_q.qn; wmask.qp = 1'b1; wdata.qp = ent_q.qp;
          end
        end
      end

      // History unlink, same pattern.
      S_HP: begin
        state_d = S_HN;
        if (was_h_q) begin
          hi_d[sid_q] = 1'b0;
          if (hl_q != '0) hl_d = hl_q - LenOne;
          if (sid_q == hh_q) begin
            hh_d = ent_q.hn;
          end else begin
            we = 1'b1; waddr = ent_q.hp; wmask.hn = 1'b1; wdata.hn = ent_q.hn;
          end
        end
      end

      S_HN: begin
        state_d = (cmd_q.opcode == pq_pkg::OpPlay) ? S_PUSH : S_OUT;
        if (was_h_q) begin
          if (sid_q == ht_q) begin
            ht_d = ent_q.hp;
          end else begin
            we = 1'b1; waddr = ent_q.hn; wmask.hp = 1'b1; wdata.hp = ent_q.hp;
          end
        end
        if (cmd_q.opcode == pq_pkg::OpDelete) reg_d[sid_q] = 1'b0;
      end

      // Enqueue: old tail's next. Play: old history head's prev.
      S_PUSH: begin
        state_d = S_PUSH2;
        if (cmd_q.opcode == pq_pkg::OpEnqueue) begin
          if (ql_q == '0) begin
            qh_d = sid_q;
          end else begin
            we = 1'b1; waddr = qt_q; wmask.qn = 1'b1; wdata.qn = sid_q;
          end
        end else begin
          if (hl_q == '0) begin
            ht_d = sid_q;
          end else begin
            we = 1'b1; waddr = hh_q; wmask.hp = 1'b1; wdata.hp = sid_q;
          end
        end
      end

      // Target's own link, then pointers and counts.
      S_PUSH2: begin
        state_d = S_OUT;
        if (cmd_q.opcode == pq_pkg::OpEnqueue) begin
          if (ql_q != '0) begin
            we = 1'b1; wmask.qp = 1'b1; wdata.qp = qt_q;
          end
          qt_d = sid_q; ql_d = ql_q + LenOne; qd_d[sid_q] = 1'b1;
          tot_d = tot_q + pq_pkg::TotW'(ent_q.dur);
        end else begin
          if (hl_q != '0) begin
            we = 1'b1; wmask.hn = 1'b1; wdata.hn = hh_q;
          end
          hh_d = sid_q; hl_d = hl_q + LenOne; hi_d[sid_q] = 1'b1;
          out_d.result_song = sid_q;
          out_d.result_valid = 1'b1;
        end
      end

      S_OUT: begin
        out_d.last = 1'b1;
        out_d.queue_total = tot_q[pq_pkg::OutTotW-1:0];
        out_d.front_valid = (ql_q != '0);
        out_d.front_song = (ql_q != '0) ? qh_q : '0;
        ov_d = 1'b1;
        state_d = S_IDLE;
      end

      S_WALK: begin
        ent_d = rdata;
        state_d = S_WOUT;
      end

      S_WOUT: begin
        if (!ov_q) begin
          out_d.status = pq_pkg::StOk;
          out_d.result_song = cur_q;
          out_d.result_valid = 1'b1;
          out_d.last = (cnt_q == LenOne);
          out_d.queue_total = tot_q[pq_pkg::OutTotW-1:0];
          out_d.front_valid = (ql_q != '0);
          out_d.front_song = (ql_q != '0) ? qh_q : '0;
          ov_d = 1'b1;
          cnt_d = cnt_q - LenOne;
          if (cnt_q == LenOne) begin
            state_d = S_IDLE;
          end else begin
            cur_d = ent_q.hn;
            re = 1'b1; raddr = ent_q.hn;
            state_d = S_WALK;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      reg_q <= '0; qd_q <= '0; hi_q <= '0;
      qh_q <= '0; qt_q <= '0; hh_q <= '0; ht_q <= '0;
      ql_q <= '0; hl_q <= '0; tot_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      reg_q <= reg_d; qd_q <= qd_d; hi_q <= hi_d;
      qh_q <= qh_d; qt_q <= qt_d; hh_q <= hh_d; ht_q <= ht_d;
      ql_q <= ql_d; hl_q <= hl_d; tot_q <= tot_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; ent_q <= ent_d; sid_q <= sid_d;
    was_q_q <= was_q_d; was_h_q <= was_h_d;
    cnt_q <= cnt_d; cur_q <= cur_d; out_q <= out_d;
  end
endmodule

// File: src/pq_mem.sv
// Entry memory: one read port, one write port with per-field mask, registered read.
module pq_mem (
  input  logic                          clk_i,
  input  logic                          re_i,
  input  logic [pq_pkg::IdW-1:0]        raddr_i,
  output pq_pkg::ent_t                  rdata_o,
  input  logic                          we_i,
  input  logic [pq_pkg::IdW-1:0]        waddr_i,
  input  pq_pkg::wmask_t                wmask_i,
  input  pq_pkg::ent_t                  wdata_i
);
  logic [pq_pkg::DurW-1:0] dur_mem [pq_pkg::Entries];
  logic [pq_pkg::IdW-1:0]  qn_mem  [pq_pkg::Entries];
  logic [pq_pkg::IdW-1:0]  qp_mem  [pq_pkg::Entries];
  logic [pq_pkg::IdW-1:0]  hn_mem  [pq_pkg::Entries];
  logic [pq_pkg::IdW-1:0]  hp_mem  [pq_pkg::Entries];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      if (wmask_i.dur) dur_mem[waddr_i] <= wdata_i.dur;
      if (wmask_i.qn)  qn_mem[waddr_i]  <= wdata_i.qn;
      if (wmask_i.qp)  qp_mem[waddr_i]  <= wdata_i.qp;
      if (wmask_i.hn)  hn_mem[waddr_i]  <= wdata_i.hn;
      if (wmask_i.hp)  hp_mem[waddr_i]  <= wdata_i.hp;
    end
    if (re_i) begin
      rdata_o.dur <= dur_mem[raddr_i];
      rdata_o.qn  <= qn_mem[raddr_i];
      rdata_o.qp  <= qp_mem[raddr_i];
      rdata_o.hn  <= hn_mem[raddr_i];
      rdata_o.hp  <= hp_mem[raddr_i];
    end
  end
endmodule

// File: src/pq_checker.sv
// Checker: port-level properties of the playlist block, bound to the top.
module pq_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         cmd_valid,
  input logic         cmd_ready,
  input logic         res_valid,
  input logic         res_ready,
  input pq_pkg::res_t res_data
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result changed under stall");
  a_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_data.front_valid |-> res_data.front_song == '0)
    else $error("front song without front valid");
  a_song: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_data.result_valid |-> res_data.result_song == '0)
    else $error("result song without result valid");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready |-> !res_valid)
    else $error("command taken while result pending");
endmodule

bind playlist_queue_with_mru_history pq_checker u_pq_checker (
  .clk_i, .rst_ni,
  .cmd_valid(cmd.valid), .cmd_ready(cmd.ready),
  .res_valid(res.valid), .res_ready(res.ready), .res_data(res.data)
);

// File: test/playlist_queue_with_mru_history_sb.sv
// Scoreboard: playlist state predictor and result checker.
`timescale 1ns / 1ps
class playlist_scoreboard;

  bit                      known[pq_pkg::Entries];
  bit                      in_queue[pq_pkg::Entries];
  logic [pq_pkg::DurW-1:0] dur_of[pq_pkg::Entries];
  int                      play_order[$];   // queue, front first
  int                      played[$];       // history, newest first
  int unsigned             queued_time;
  pq_pkg::res_t            pending[$];
  int                      errors;

  function new();
    errors = 0;
    queued_time = 0;
    foreach (known[i]) begin
      known[i] = 0;
      in_queue[i] = 0;
      dur_of[i] = '0;
    end
  endfunction

  function automatic pq_pkg::res_t make_res(logic [1:0] st, int song, bit sv, bit lst);
    pq_pkg::res_t r;
    r.status       = st;
    r.result_song  = sv ? song[pq_pkg::IdW-1:0] : '0;
    r.result_valid = sv;
    r.last         = lst;
    r.queue_total  = queued_time[pq_pkg::OutTotW-1:0];
    r.front_valid  = play_order.size() != 0;
    r.front_song   = r.front_valid ? play_order[0][pq_pkg::IdW-1:0] : '0;
    return r;
  endfunction

  function automatic void drop(ref int lst[$], input int id);
    foreach (lst[i]) begin
      if (lst[i] == id) begin
        lst.delete(i);
        return;
      end
    end
  endfunction

  function void note_command(pq_pkg::cmd_t c);
    int id;
    int cnt;
    int s;
    id = c.song_id;
    case (c.opcode)
      pq_pkg::OpRegister: begin
        if (known[id]) pending.push_back(make_res(pq_pkg::StExists, 0, 0, 1));
        else begin
          known[id] = 1;
          dur_of[id] = c.duration;
          pending.push_back(make_res(pq_pkg::StOk, 0, 0, 1));
        end
      end
      pq_pkg::OpEnqueue: begin
        if (!known[id]) pending.push_back(make_res(pq_pkg::StUnknown, 0, 0, 1));
        else begin
          if (!in_queue[id]) begin
            in_queue[id] = 1;
            play_order.push_back(id);
            queued_time += dur_of[id];
          end
          pending.push_back(make_res(pq_pkg::StOk, 0, 0, 1));
        end
      end
      pq_pkg::OpPlay: begin
        if (play_order.size() == 0) pending.push_back(make_res(pq_pkg::StEmpty, 0, 0, 1));
        else begin
          s = play_order[0];
          play_order.delete(0);
          in_queue[s] = 0;
          queued_time -= dur_of[s];
          drop(played, s);
          played.insert(0, s);
          pending.push_back(make_res(pq_pkg::StOk, s, 1, 1));
        end
      end
      pq_pkg::OpRecent: begin
        cnt = c.count_asked;
        if (cnt > pq_pkg::MaxRes) cnt = pq_pkg::MaxRes;
        if (cnt > played.size()) cnt = played.size();
        if (cnt == 0) pending.push_back(make_res(pq_pkg::StOk, 0, 0, 1));
        for (int k = 0; k < cnt; k++)
          pending.push_back(make_res(pq_pkg::StOk, played[k], 1, k + 1 == cnt));
      end
      pq_pkg::OpDelete: begin
        if (known[id]) begin
          if (in_queue[id]) begin
            in_queue[id] = 0;
            queued_time -= dur_of[id];
            drop(play_order, id);
          end
          drop(played, id);
          known[id] = 0;
        end
        pending.push_back(make_res(pq_pkg::StOk, 0, 0, 1));
      end
      default: pending.push_back(make_res(pq_pkg::StOk, 0, 0, 1));
    endcase
  endfunction

  function void check_result(pq_pkg::res_t got);
    pq_pkg::res_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    want = pending[0];
    pending.delete(0);
    if (got.status !== want.status)
      $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
    if (got.result_song !== want.result_song)
      $display("%0t: result_song exp %0d got %0d", $time, want.result_song, got.result_song);
    if (got.result_valid !== want.result_valid)
      $display("%0t: result_valid exp %0b got %0b", $time, want.result_valid,
               got.result_valid);
    if (got.last !== want.last)
      $display("%0t: last exp %0b got %0b", $time, want.last, got.last);
    if (got.queue_total !== want.queue_total)
      $display("%0t: queue_total exp %0d got %0d", $time, want.queue_total, got.queue_total);
    if (got.front_song !== want.front_song)
      $display("%0t: front_song exp %0d got %0d", $time, want.front_song, got.front_song);
    if (got.front_valid !== want.front_valid)
      $display("%0t: front_valid exp %0b got %0b", $time, want.front_valid, got.front_valid);
    if (got !== want) errors++;
  endfunction
endclass

// File: test/playlist_queue_with_mru_history_tb.sv
// Testbench top: directed and random playlist commands against the predictor.
`timescale 1ns / 1ps
module playlist_queue_with_mru_history_tb;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  pq_cmd_if cmd ();
  pq_res_if res ();

  playlist_queue_with_mru_history dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd    (cmd.sink),
    .res    (res.source)
  );

  playlist_scoreboard board;

  // Idle rates in percent; hold_res forces a long receiver stall.
  int  send_idle;
  int  recv_idle;
  bit  hold_res;
  longint cycles = 0;

  localparam longint CycleLimit = 400000;

  initial begin
    cmd.valid = 1'b0;
    cmd.data  = '0;
    res.ready = 1'b0;
    hold_res  = 1'b0;
    send_idle = 27;
    recv_idle = 79;
    board     = new();
  end

  // Receiver: random ready, checks each result transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res.valid && res.ready) board.check_result(res.data);
      res.ready <= !hold_res && ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL playlist_queue_with_mru_history");
      $finish;
    end
  end

  // Offer one command, hold it until transferred; gaps before at send_idle rate.
  task automatic send_cmd(pq_pkg::cmd_t c);
    while ($urandom_range(99) < send_idle) begin
      cmd.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd.valid <= 1'b1;
    cmd.data  <= c;
    do @(posedge clk_i); while (!cmd.ready);
    board.note_command(c);
  endtask

  task automatic send_op(logic [2:0] op, int id, int dur, int n);
    pq_pkg::cmd_t c;
    c.opcode      = op;
    c.song_id     = id[pq_pkg::IdW-1:0];
    c.duration    = dur[pq_pkg::DurW-1:0];
    c.count_asked = n[6:0];
    send_cmd(c);
  endtask

  task automatic wait_drained();
    cmd.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending.size() != 0);
  endtask

  // Random command mix: well-formed traffic over a small id pool, plus noise.
  task automatic random_cmds(int count);
    pq_pkg::cmd_t c;
    int pick;
    logic [31:0] rnd;
    for (int i = 0; i < count; i++) begin
      rnd = ($urandom_range(3) == 0) ? $urandom : $urandom_range(11);
      c.opcode      = pq_pkg::OpRegister;
      c.song_id     = rnd[pq_pkg::IdW-1:0];
      rnd = $urandom;
      c.duration    = rnd[pq_pkg::DurW-1:0];
      rnd = $urandom_range(9);
      c.count_asked = rnd[6:0];
      pick = $urandom_range(99);
      if      (pick < 18) c.opcode = pq_pkg::OpRegister;
      else if (pick < 45) c.opcode = pq_pkg::OpEnqueue;
      else if (pick < 68) c.opcode = pq_pkg::OpPlay;
      else if (pick < 82) c.opcode = pq_pkg::OpRecent;
      else if (pick < 93) c.opcode = pq_pkg::OpDelete;
      else begin
        rnd = $urandom;
        c.opcode = rnd[2:0];
        c.count_asked = rnd[9:3];
      end
      send_cmd(c);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty cases, extremes, duplicates, deletes, unused opcodes.
    send_op(pq_pkg::OpPlay, 0, 0, 0);
    send_op(pq_pkg::OpRecent, 0, 0, 64);
    send_op(pq_pkg::OpEnqueue, 5, 0, 0);
    send_op(pq_pkg::OpRegister, 0, 16'hFFFF, 0);
    send_op(pq_pkg::OpRegister, 63, 16'hFFFF, 127);
    send_op(pq_pkg::OpRegister, 63, 1, 0);
    send_op(pq_pkg::OpRegister, 42, 0, 0);
    send_op(pq_pkg::OpEnqueue, 0, 0, 0);
    send_op(pq_pkg::OpEnqueue, 63, 0, 0);
    send_op(pq_pkg::OpEnqueue, 63, 0, 0);
    send_op(pq_pkg::OpEnqueue, 42, 0, 0);
    send_op(pq_pkg::OpPlay, 0, 0, 0);
    send_op(pq_pkg::OpEnqueue, 0, 0, 0);
    send_op(pq_pkg::OpPlay, 0, 0, 0);
    send_op(pq_pkg::OpPlay, 0, 0, 0);
    send_op(pq_pkg::OpRecent, 0, 0, 127);
    send_op(pq_pkg::OpRecent, 0, 0, 1);
    send_op(pq_pkg::OpDelete, 63, 0, 0);
    send_op(pq_pkg::OpDelete, 21, 0, 0);
    send_op(pq_pkg::OpRecent, 0, 0, 64);
    send_op(3'd5, 63, 16'hFFFF, 127);
    send_op(3'd7, 0, 0, 0);
    send_op(pq_pkg::OpPlay, 0, 0, 0);
    send_op(pq_pkg::OpPlay, 0, 0, 0);
    wait_drained();

    // Fill history with a block of entries, then list all of it.
    for (int i = 0; i < 16; i++) send_op(pq_pkg::OpRegister, i, $urandom, 0);
    for (int i = 0; i < 16; i++) send_op(pq_pkg::OpEnqueue, i, 0, 0);
    for (int i = 0; i < 16; i++) send_op(pq_pkg::OpPlay, 0, 0, 0);
    send_op(pq_pkg::OpRecent, 0, 0, 100);

    random_cmds(30);
    send_idle = 79; recv_idle = 27;
    random_cmds(35);

    // Long receiver stall while commands keep coming; then drain fully.
    send_idle = 0; recv_idle = 0;
    hold_res = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_res = 1'b0;
      end
      random_cmds(20);
    join
    wait_drained();
    random_cmds(22);

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("PASS playlist_queue_with_mru_history");
    else
      $display("FAIL playlist_queue_with_mru_history");
    $finish;
  end
endmodule
